// ===== src/lprd_pkg.sv =====
// Shared types and constants for the length-prefixed record deframer.
// No dependencies; used by every module under src.
package lprd_pkg;

  localparam int unsigned MAX_RECORD_BYTES = 512;
  localparam int unsigned MAX_RECORDS      = 256;
  localparam int unsigned MAX_BUFFER_BYTES = 65536;

  localparam int unsigned POS_W = 17;  // byte position and buffer length
  localparam int unsigned LEN_W = 10;  // effective record length
  localparam int unsigned CNT_W = 9;   // completed record count

  localparam logic [POS_W-1:0] POS_MAX  = {POS_W{1'b1}};
  localparam logic [POS_W-1:0] BUF_MAX  = POS_W'(MAX_BUFFER_BYTES);
  localparam logic [POS_W-1:0] REC_MAX  = POS_W'(MAX_RECORD_BYTES);
  localparam logic [CNT_W-1:0] RECS_MAX = CNT_W'(MAX_RECORDS);

  typedef enum logic [2:0] {
    PH_MODE,
    PH_HDR_LO,
    PH_HDR_HI,
    PH_PAYLOAD,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    KIND_MODE,
    KIND_PAYLOAD,
    KIND_EMPTY
  } kind_t;

  typedef struct packed {
    logic       start_of_buffer;
    logic [7:0] in_byte;
  } item_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] out_byte;
    logic [7:0] record_index;
    logic [8:0] byte_offset;
    logic [9:0] record_length;
    logic       last_of_record;
  } result_t;

endpackage

// ===== src/lprd_parser.sv =====
// Header/payload parser: phase state machine and per-record counters.
// Depends on lprd_pkg. Produces at most one result per accepted byte.
module lprd_parser (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  lprd_pkg::item_t             item,
  input  logic [lprd_pkg::POS_W-1:0]  buffer_length,
  output logic                        emit,
  output lprd_pkg::result_t           result
);

  lprd_pkg::phase_t              phase, phase_next;
  logic [lprd_pkg::POS_W-1:0]    byte_position, byte_position_next;
  logic [7:0]                    length_low_byte, length_low_byte_next;
  logic [lprd_pkg::LEN_W-1:0]    current_length, current_length_next;
  logic [lprd_pkg::LEN_W-1:0]    payload_offset, payload_offset_next;
  logic [lprd_pkg::CNT_W-1:0]    record_count, record_count_next;

  // view of the state after an optional restart
  lprd_pkg::phase_t              cur_phase;
  logic [lprd_pkg::POS_W-1:0]    cur_pos;
  logic [7:0]                    cur_lo;
  logic [lprd_pkg::LEN_W-1:0]    cur_len;
  logic [lprd_pkg::LEN_W-1:0]    cur_off;
  logic [lprd_pkg::CNT_W-1:0]    cur_cnt;

  logic [lprd_pkg::POS_W-1:0]    size;
  logic [lprd_pkg::POS_W-1:0]    remain;
  logic [15:0]                   hdr;
  logic [lprd_pkg::POS_W-1:0]    len_cap;
  logic [lprd_pkg::LEN_W-1:0]    len_eff;
  logic                          last;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= lprd_pkg::PH_MODE;
      byte_position   <= '0;
      length_low_byte <= '0;
      current_length  <= '0;
      payload_offset  <= '0;
      record_count    <= '0;
    end else if (accept) begin
      phase           <= phase_next;
      byte_position   <= byte_position_next;
      length_low_byte <= length_low_byte_next;
      current_length  <= current_length_next;
      payload_offset  <= payload_offset_next;
      record_count    <= record_count_next;
    end
  end

  always_comb begin
    size = (buffer_length > lprd_pkg::BUF_MAX) ? lprd_pkg::BUF_MAX : buffer_length;

    cur_phase = item.start_of_buffer ? lprd_pkg::PH_MODE : phase;
    cur_pos   = item.start_of_buffer ? '0 : byte_position;
    cur_lo    = item.start_of_buffer ? '0 : length_low_byte;
    cur_len   = item.start_of_buffer ? '0 : current_length;
    cur_off   = item.start_of_buffer ? '0 : payload_offset;
    cur_cnt   = item.start_of_buffer ? '0 : record_count;

    byte_position_next   = (cur_pos == lprd_pkg::POS_MAX) ? cur_pos
                                                          : cur_pos + 1'b1;
    phase_next           = cur_phase;
    length_low_byte_next = cur_lo;
    current_length_next  = cur_len;
    payload_offset_next  = cur_off;
    record_count_next    = cur_cnt;

    // header length, capped by bytes left after the header, then by max size
    hdr     = {item.in_byte, cur_lo};
    remain  = size - cur_pos - 1'b1;
    len_cap = ({1'b0, hdr} > remain) ? remain : {1'b0, hdr};
    len_eff = (len_cap > lprd_pkg::REC_MAX) ? lprd_pkg::LEN_W'(lprd_pkg::REC_MAX)
                                            : len_cap[lprd_pkg::LEN_W-1:0];
    last    = ({1'b0, cur_off} + 1'b1) >= {1'b0, cur_len};

    emit   = 1'b0;
    result = '0;

    if (cur_pos < size) begin
      case (cur_phase)
        lprd_pkg::PH_MODE: begin
          emit            = 1'b1;
          result.kind     = lprd_pkg::KIND_MODE;
          result.out_byte = item.in_byte;
          phase_next      = lprd_pkg::PH_HDR_LO;
        end
        lprd_pkg::PH_HDR_LO: begin
          if (cur_cnt >= lprd_pkg::RECS_MAX) begin
            phase_next = lprd_pkg::PH_DONE;
          end else if (cur_pos == size - 1'b1) begin
            // lone byte at the end; a two-byte buffer makes it a record
            if (size == lprd_pkg::POS_W'(2) && cur_cnt == '0) begin
              emit                  = 1'b1;
              result.kind           = lprd_pkg::KIND_PAYLOAD;
              result.out_byte       = item.in_byte;
              result.record_length  = 10'd1;
              result.last_of_record = 1'b1;
              record_count_next     = lprd_pkg::CNT_W'(1);
            end
            phase_next = lprd_pkg::PH_DONE;
          end else begin
            length_low_byte_next = item.in_byte;
            phase_next           = lprd_pkg::PH_HDR_HI;
          end
        end
        lprd_pkg::PH_HDR_HI: begin
          current_length_next = len_eff;
          payload_offset_next = '0;
          if (len_eff == '0) begin
            emit                  = 1'b1;
            result.kind           = lprd_pkg::KIND_EMPTY;
            result.record_index   = cur_cnt[7:0];
            result.last_of_record = 1'b1;
            record_count_next     = cur_cnt + 1'b1;
            phase_next            = lprd_pkg::PH_HDR_LO;
          end else begin
            phase_next = lprd_pkg::PH_PAYLOAD;
          end
        end
        lprd_pkg::PH_PAYLOAD: begin
          emit                  = 1'b1;
          result.kind           = lprd_pkg::KIND_PAYLOAD;
          result.out_byte       = item.in_byte;
          result.record_index   = cur_cnt[7:0];
          result.byte_offset    = cur_off[8:0];
          result.record_length  = cur_len;
          result.last_of_record = last;
          payload_offset_next   = cur_off + 1'b1;
          if (last) begin
            record_count_next = cur_cnt + 1'b1;
            phase_next        = lprd_pkg::PH_HDR_LO;
          end
        end
        default: begin
          // done: drop
        end
      endcase
    end
  end

endmodule

// ===== src/lprd_out_reg.sv =====
// Result register with valid/stall handshake toward the consumer.
// Depends on lprd_pkg for the result struct.
module lprd_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic              load_valid,
  input  lprd_pkg::result_t load_data,
  output logic              result_valid,
  input  logic              result_stall,
  output lprd_pkg::result_t result,
  output logic              full
);

  logic result_valid_next;

  // full means the held result cannot leave this cycle
  assign full = result_valid && result_stall;

  always_comb begin
    if (load) begin
      result_valid_next = load_valid;
    end else if (result_valid && !result_stall) begin
      result_valid_next = 1'b0;
    end else begin
      result_valid_next = result_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load && load_valid) begin
      result <= load_data;
    end
  end

endmodule

// ===== src/length_prefixed_record_deframer.sv =====
// Top level of the length-prefixed record deframer (16-bit LE headers).
// Depends on lprd_pkg, lprd_parser and lprd_out_reg.
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+--------------------
//  item     | in        | item_valid / item_stall   | item   (item_t)
//  result   | out       | result_valid / result_stall| result (result_t)
//  config   | in        | cfg_we                    | cfg_wdata (17 bits)
//
// One byte per clock while item is not stalled: a transaction on item updates
// the parser state and loads at most one result into the output register
// on the same edge. The new result register is the only stage; item is
// stalled only while a held result is itself stalled downstream. Reset (rst,
// synchronous) puts the parser back to expecting the mode byte and clears
// buffer_length; the result register comes out empty.
module length_prefixed_record_deframer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  lprd_pkg::item_t             item,
  output logic                        result_valid,
  input  logic                        result_stall,
  output lprd_pkg::result_t           result,
  input  logic                        cfg_we,
  input  logic [lprd_pkg::POS_W-1:0]  cfg_wdata
);

  logic [lprd_pkg::POS_W-1:0] buffer_length;
  logic                       accept;
  logic                       emit;
  lprd_pkg::result_t          parsed;
  logic                       out_full;

  // buffer length register, to be written only while idle; the block itself does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_length <= '0;
    end else if (cfg_we) begin
      buffer_length <= cfg_wdata;
    end
  end

  assign item_stall = out_full;
  assign accept     = item_valid && !item_stall;

  lprd_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .item          (item),
    .buffer_length (buffer_length),
    .emit          (emit),
    .result        (parsed)
  );

  // a byte that produces nothing still empties the register if it drains
  lprd_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .load         (accept),
    .load_valid   (emit),
    .load_data    (parsed),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .full         (out_full)
  );

endmodule
